// File: src/ercl_pkg.sv
// ercl_pkg: types and constants shared by the event report coalescer modules
// no dependencies; imported by ercl_table, ercl_out_reg and event_report_coalescer_core
package ercl_pkg;

  localparam int TIME_W     = 48;
  localparam int COUNT_W    = 32;
  localparam int INTERVAL_W = 32;
  localparam int EVNUM_W    = 5;
  localparam int KIND_W     = 2;

  localparam logic [COUNT_W-1:0]    COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

  // request types
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REPORT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUPPRESSED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH_DONE = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic [EVNUM_W-1:0] event_number;
    logic [TIME_W-1:0]  now_time;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [EVNUM_W-1:0] report_number;
    logic [COUNT_W-1:0] repeat_count;
    logic               last;
  } rsp_t;

  // one table entry: pending repeats and time of last report
  typedef struct packed {
    logic [COUNT_W-1:0] repeat_count;
    logic [TIME_W-1:0]  report_time;
  } entry_t;

endpackage

// File: src/ercl_table.sv
// ercl_table: per-event state memory, one write and one registered read port
// entries without a valid bit read as zero; depends on ercl_pkg
module ercl_table import ercl_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  output entry_t        rd_data
);

  entry_t             mem [DEPTH];
  logic   [DEPTH-1:0] vld;
  entry_t             rd_raw;
  logic               rd_vld;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

// File: src/ercl_out_reg.sv
// ercl_out_reg: result register between the sequencer and the output channel
// depends on ercl_pkg
module ercl_out_reg import ercl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t push_data,
  output logic free,
  output logic valid,
  input  logic ready,
  output rsp_t data
);

  // slot can take a new result when empty or being drained
  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

endmodule

// File: src/event_report_coalescer_core.sv
// event_report_coalescer_core: per-event coalescing with timed flush summaries
// in-range event: entry read, then a result pushed once the output register is free
// flush: scans entries from 0 up to the highest event number seen, then pushes a done result;
//   summaries of expired pending entries stall only while the output slot is taken
// one transaction in work at a time; output stalls hold the table read in place
// reset clears the table valid bits at once, no clearing pass; interval resets to 1000
module event_report_coalescer_core import ercl_pkg::*; #(
  parameter int NUM_EVENTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INTERVAL_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(NUM_EVENTS);
  localparam int EXT_W = ((IDX_W > EVNUM_W) ? IDX_W : EVNUM_W) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EV_EVAL  = 3'd1;
  localparam logic [2:0] S_FL_EVAL  = 3'd2;
  localparam logic [2:0] S_FL_DONE  = 3'd3;

  logic [2:0]            state, state_next;
  logic [IDX_W-1:0]      cur_idx, cur_idx_next;
  logic [TIME_W-1:0]     cur_time, cur_time_next;
  logic [IDX_W-1:0]      highest, highest_next;
  logic [INTERVAL_W-1:0] interval;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           wr_data, rd_data;

  logic push, out_free;
  rsp_t push_data;

  logic [EXT_W-1:0] ev_ext, cur_ext;
  logic             in_range;
  logic [IDX_W-1:0] ev_idx;
  logic [TIME_W:0]  deadline;
  logic             expired, pending, req_fire;

  ercl_table #(.DEPTH(NUM_EVENTS), .AW(IDX_W)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (cur_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  ercl_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .free      (out_free),
    .valid     (rsp_valid),
    .ready     (rsp_ready),
    .data      (rsp)
  );

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      interval <= cfg_data;
    end
  end

  // event number range check and index
  assign ev_ext   = EXT_W'(req.event_number);
  assign in_range = ev_ext < EXT_W'(NUM_EVENTS);
  assign ev_idx   = ev_ext[IDX_W-1:0];
  assign cur_ext  = EXT_W'(cur_idx);

  // expiry test on the entry just read, exact 49-bit compare
  assign deadline = {1'b0, rd_data.report_time} + (TIME_W+1)'(interval);
  assign expired  = {1'b0, cur_time} > deadline;
  assign pending  = rd_data.repeat_count != '0;

  assign req_ready = state == S_IDLE;
  assign req_fire  = req_valid && req_ready;

  // sequencer
  always_comb begin
    state_next    = state;
    cur_idx_next  = cur_idx;
    cur_time_next = cur_time;
    highest_next  = highest;
    rd_en         = 1'b0;
    rd_addr       = cur_idx;
    wr_en         = 1'b0;
    wr_data       = rd_data;
    push          = 1'b0;
    push_data     = '0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          cur_time_next = req.now_time;
          if (req.req_type == REQ_FLUSH) begin
            rd_en        = 1'b1;
            rd_addr      = '0;
            cur_idx_next = '0;
            state_next   = S_FL_EVAL;
          end else if (in_range) begin
            rd_en        = 1'b1;
            rd_addr      = ev_idx;
            cur_idx_next = ev_idx;
            if (ev_idx > highest) begin
              highest_next = ev_idx;
            end
            state_next = S_EV_EVAL;
          end
        end
      end
      S_EV_EVAL: begin
        if (out_free) begin
          wr_en                   = 1'b1;
          push                    = 1'b1;
          push_data.report_number = cur_ext[EVNUM_W-1:0];
          push_data.last          = 1'b1;
          if (!pending && expired) begin
            wr_data.report_time   = cur_time;
            push_data.result_kind = KIND_REPORT;
          end else begin
            if (rd_data.repeat_count != COUNT_MAX) begin
              wr_data.repeat_count = rd_data.repeat_count + COUNT_W'(1);
            end
            push_data.result_kind = KIND_SUPPRESSED;
          end
          state_next = S_IDLE;
        end
      end
      S_FL_EVAL: begin
        // stall only when a summary is due and the output slot is taken
        if (!(pending && expired) || out_free) begin
          if (pending && expired) begin
            wr_en                   = 1'b1;
            wr_data                 = '0;
            push                    = 1'b1;
            push_data.result_kind   = KIND_SUMMARY;
            push_data.report_number = cur_ext[EVNUM_W-1:0];
            push_data.repeat_count  = rd_data.repeat_count;
          end
          if (cur_idx == highest) begin
            state_next = S_FL_DONE;
          end else begin
            cur_idx_next = cur_idx + IDX_W'(1);
            rd_en        = 1'b1;
            rd_addr      = cur_idx_next;
          end
        end
      end
      S_FL_DONE: begin
        if (out_free) begin
          push                  = 1'b1;
          push_data.result_kind = KIND_FLUSH_DONE;
          push_data.last        = 1'b1;
          state_next            = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      highest <= '0;
    end else begin
      state   <= state_next;
      highest <= highest_next;
    end
  end

  // working item registers
  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    cur_time <= cur_time_next;
  end

endmodule
